[rtl/depth_backproject_rigid_transform_unit_defines.svh]
// assertion macros for the depth back-projection unit
`ifndef DEPTH_BACKPROJECT_RIGID_TRANSFORM_UNIT_DEFINES_SVH
`define DEPTH_BACKPROJECT_RIGID_TRANSFORM_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define DBP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define DBP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dbp_pkg.sv]
// shared types and constants for the depth back-projection unit
`timescale 1ns / 1ps
`default_nettype none

package dbp_pkg;

    localparam int DEPTH_ROWS_DEF = 480;
    localparam int DEPTH_COLS_DEF = 640;
    localparam int IMAGE_ROWS_DEF = 960;
    localparam int IMAGE_COLS_DEF = 1280;

    localparam int STAGES = 6;

    localparam int ROW_IDX_W = 9;
    localparam int COL_IDX_W = 10;
    localparam int RAW_W     = 18;
    localparam int DEPTH_W   = 16;
    localparam int ROT_W     = 18;
    localparam int ROT_ROW_W = 3 * ROT_W;
    localparam int SHIFT_W   = 24;
    localparam int FOCAL_W   = 24;
    localparam int PT_W      = 24;
    localparam int IMG_ROW_W = 10;
    localparam int IMG_COL_W = 11;

    localparam int OFS_W  = 15;
    localparam int PD_W   = 32;
    localparam int PF_W   = 57;
    localparam int XY_W   = 32;
    localparam int PROD_W = 50;
    localparam int ACC_W  = 53;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROT_ROW_W;

    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = 16'd44800;

    localparam logic [ROT_ROW_W-1:0] ROT_ROW0_RST = 54'd65536;
    localparam logic [ROT_ROW_W-1:0] ROT_ROW1_RST = 54'd65536 << ROT_W;
    localparam logic [ROT_ROW_W-1:0] ROT_ROW2_RST = 54'd65536 << (2 * ROT_W);
    localparam logic [FOCAL_W-1:0]   INV_FOCAL_RST = 24'd33554;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_ROW0  = 3'd0,
        REG_ROT_ROW1  = 3'd1,
        REG_ROT_ROW2  = 3'd2,
        REG_SHIFT_X   = 3'd3,
        REG_SHIFT_Y   = 3'd4,
        REG_SHIFT_Z   = 3'd5,
        REG_INV_FOCAL = 3'd6
    } cfg_reg_e;

    // per-stage load strobes, bit 0 is the first stage
    typedef struct packed {
        logic [STAGES-1:0] load;
    } stage_ctrl_t;

endpackage

`default_nettype wire

[rtl/dbp_project.sv]
// pinhole back-projection of one depth pixel, stages one to three
`timescale 1ns / 1ps
`default_nettype none

module dbp_project
    import dbp_pkg::*;
#(
    parameter int DEPTH_ROWS = DEPTH_ROWS_DEF,
    parameter int DEPTH_COLS = DEPTH_COLS_DEF
)
(
    input  wire logic                    clk,
    input  wire stage_ctrl_t             ctrl,
    input  wire logic [ROW_IDX_W-1:0]    pixel_row,
    input  wire logic [COL_IDX_W-1:0]    pixel_col,
    input  wire logic [DEPTH_W-1:0]      depth,
    input  wire logic [FOCAL_W-1:0]      inv_focal,
    output logic signed [XY_W-1:0]       cam_x,
    output logic signed [XY_W-1:0]       cam_y
);

    localparam logic signed [OFS_W-1:0] COL_OFS = OFS_W'(DEPTH_COLS);
    localparam logic signed [OFS_W-1:0] ROW_OFS = OFS_W'(DEPTH_ROWS);
    localparam logic signed [PF_W-1:0]  HALF    = PF_W'(64'd1 << 24);

    logic signed [OFS_W-1:0]   dx2;
    logic signed [OFS_W-1:0]   dy2;
    logic signed [DEPTH_W:0]   depth_s;
    logic signed [FOCAL_W:0]   focal_s;
    logic signed [PD_W-1:0]    pdx_next;
    logic signed [PD_W-1:0]    pdy_next;
    logic signed [PD_W-1:0]    pdx_reg;
    logic signed [PD_W-1:0]    pdy_reg;
    logic signed [PF_W-1:0]    pfx_next;
    logic signed [PF_W-1:0]    pfy_next;
    logic signed [PF_W-1:0]    pfx_reg;
    logic signed [PF_W-1:0]    pfy_reg;
    logic signed [PF_W-1:0]    rx_sum;
    logic signed [PF_W-1:0]    ry_sum;
    logic signed [XY_W-1:0]    x_next;
    logic signed [XY_W-1:0]    y_next;
    logic signed [XY_W-1:0]    x_reg;
    logic signed [XY_W-1:0]    y_reg;

    // twice the offset from the centre keeps the half pixel exact
    assign dx2     = $signed(OFS_W'({pixel_col, 1'b0})) - COL_OFS;
    assign dy2     = $signed(OFS_W'({pixel_row, 1'b0})) - ROW_OFS;
    assign depth_s = $signed({1'b0, depth});
    assign focal_s = $signed({1'b0, inv_focal});

    assign pdx_next = dx2 * depth_s;
    assign pdy_next = dy2 * depth_s;

    assign pfx_next = pdx_reg * focal_s;
    assign pfy_next = pdy_reg * focal_s;

    // round half up, drop 25 fraction bits
    assign rx_sum = pfx_reg + HALF;
    assign ry_sum = pfy_reg + HALF;
    assign x_next = rx_sum[PF_W-1:25];
    assign y_next = ry_sum[PF_W-1:25];

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            pdx_reg <= pdx_next;
            pdy_reg <= pdy_next;
        end
        if (ctrl.load[1])
        begin
            pfx_reg <= pfx_next;
            pfy_reg <= pfy_next;
        end
        if (ctrl.load[2])
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign cam_x = x_reg;
    assign cam_y = y_reg;

endmodule

`default_nettype wire

[rtl/dbp_rotate.sv]
// rotation, translation, rounding and saturation, stages four to six
`timescale 1ns / 1ps
`default_nettype none

module dbp_rotate
    import dbp_pkg::*;
(
    input  wire logic                    clk,
    input  wire stage_ctrl_t             ctrl,
    input  wire logic signed [XY_W-1:0]  cam_x,
    input  wire logic signed [XY_W-1:0]  cam_y,
    input  wire logic [DEPTH_W-1:0]      cam_z,
    input  wire logic [ROT_ROW_W-1:0]    rot_row [3],
    input  wire logic [SHIFT_W-1:0]      shift_val [3],
    output logic signed [PT_W-1:0]       point [3]
);

    localparam int QW = ACC_W - 16;
    localparam logic signed [QW-1:0] PT_MAX = QW'(64'sd8388607);
    localparam logic signed [QW-1:0] PT_MIN = -QW'(64'sd8388608);

    logic signed [XY_W-1:0] operand [3];

    assign operand[0] = cam_x;
    assign operand[1] = cam_y;
    assign operand[2] = $signed(XY_W'(cam_z));

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        logic signed [PROD_W-1:0]  prod_next [3];
        logic signed [PROD_W-1:0]  prod_reg [3];
        logic signed [ACC_W-1:0]   sum_a_next;
        logic signed [ACC_W-1:0]   sum_b_next;
        logic signed [ACC_W-1:0]   sum_a_reg;
        logic signed [ACC_W-1:0]   sum_b_reg;
        logic signed [ACC_W-1:0]   acc;
        logic signed [QW-1:0]      acc_q;
        logic signed [PT_W-1:0]    point_next;
        logic signed [PT_W-1:0]    point_reg;

        for (genvar k = 0; k < 3; k++)
        begin : g_term
            assign prod_next[k] = $signed(rot_row[a][k*ROT_W +: ROT_W]) * operand[k];
        end

        // shift as a signed 24-bit integer (Q24.0) above 16 fraction bits, plus the rounding half
        assign sum_a_next = ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1]);
        assign sum_b_next = ACC_W'(prod_reg[2])
                          + ACC_W'($signed({shift_val[a], 16'h8000}));

        assign acc   = sum_a_reg + sum_b_reg;
        assign acc_q = acc[ACC_W-1:16];

        always_comb
        begin
            if (acc_q > PT_MAX)
                point_next = PT_MAX[PT_W-1:0];
            else if (acc_q < PT_MIN)
                point_next = PT_MIN[PT_W-1:0];
            else
                point_next = acc_q[PT_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.load[3])
                prod_reg <= prod_next;
            if (ctrl.load[4])
            begin
                sum_a_reg <= sum_a_next;
                sum_b_reg <= sum_b_next;
            end
            if (ctrl.load[5])
                point_reg <= point_next;
        end

        assign point[a] = point_reg;
    end

endmodule

`default_nettype wire

[rtl/dbp_index.sv]
// rounded, clamped rescale of a pixel index to the colour image
`timescale 1ns / 1ps
`default_nettype none

module dbp_index
    import dbp_pkg::*;
#(
    parameter int IDX_W = ROW_IDX_W,
    parameter int OUT_W = IMG_ROW_W,
    parameter int TO    = IMAGE_ROWS_DEF,
    parameter int FROM  = DEPTH_ROWS_DEF
)
(
    input  wire logic               clk,
    input  wire stage_ctrl_t        ctrl,
    input  wire logic [IDX_W-1:0]   idx,
    output logic [OUT_W-1:0]        scaled
);

    localparam int D    = 2 * FROM;
    localparam int NA   = IDX_W + $clog2(TO) + 1;
    localparam int NB   = $clog2(FROM);
    localparam int NW   = ((NA > NB) ? NA : NB) + 1;
    localparam int DW   = $clog2(D) + 1;
    localparam int S    = NW + DW;
    localparam int PW   = S + NW;

    localparam logic [PW-1:0] MULT   = PW'((64'd1 << S) / D);
    localparam logic [NW-1:0] TO_N   = NW'(TO);
    localparam logic [NW-1:0] FROM_N = NW'(FROM);
    localparam logic [NW:0]   D_N    = (NW + 1)'(D);
    localparam logic [NW:0]   TOP_N  = (NW + 1)'(TO - 1);

    logic [NW-1:0]    n_next;
    logic [NW-1:0]    n1_reg;
    logic [PW-1:0]    prod_next;
    logic [PW-1:0]    prod_reg;
    logic [NW-1:0]    n2_reg;
    logic [NW-1:0]    qe_next;
    logic [NW-1:0]    qd_next;
    logic [NW-1:0]    qe_reg;
    logic [NW-1:0]    qd_reg;
    logic [NW-1:0]    n3_reg;
    logic [NW-1:0]    rem;
    logic [NW:0]      q_full;
    logic [OUT_W-1:0] q_next;
    logic [OUT_W-1:0] q4_reg;
    logic [OUT_W-1:0] q5_reg;
    logic [OUT_W-1:0] q6_reg;

    assign n_next    = NW'({idx, 1'b0}) * TO_N + FROM_N;
    assign prod_next = PW'(n1_reg) * MULT;

    // reciprocal estimate is exact or one low
    assign qe_next = prod_reg[S +: NW];
    assign qd_next = NW'(qe_next * D_N);

    assign rem    = n3_reg - qd_reg;
    assign q_full = {1'b0, qe_reg} + (({1'b0, rem} >= D_N) ? (NW + 1)'(1) : '0);

    always_comb
    begin
        if (q_full > TOP_N)
            q_next = OUT_W'(TOP_N);
        else
            q_next = OUT_W'(q_full);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
            n1_reg <= n_next;
        if (ctrl.load[1])
        begin
            prod_reg <= prod_next;
            n2_reg   <= n1_reg;
        end
        if (ctrl.load[2])
        begin
            qe_reg <= qe_next;
            qd_reg <= qd_next;
            n3_reg <= n2_reg;
        end
        if (ctrl.load[3])
            q4_reg <= q_next;
        if (ctrl.load[4])
            q5_reg <= q4_reg;
        if (ctrl.load[5])
            q6_reg <= q5_reg;
    end

    assign scaled = q6_reg;

endmodule

`default_nettype wire

[rtl/depth_backproject_rigid_transform_unit.sv]
// top level of the depth back-projection and rigid transform unit
// throughput: one transaction per cycle while the output is not stalled, through the six-stage multiply pipeline
// each stage holds when it is full and its successor cannot take data, so bubbles close up under stall
// reset clears all stage valid flags and loads the identity rotation,
// zero translation and the default reciprocal focal length
`timescale 1ns / 1ps
`default_nettype none

`include "depth_backproject_rigid_transform_unit_defines.svh"

module depth_backproject_rigid_transform_unit
    import dbp_pkg::*;
#(
    parameter int DEPTH_ROWS = DEPTH_ROWS_DEF,
    parameter int DEPTH_COLS = DEPTH_COLS_DEF,
    parameter int IMAGE_ROWS = IMAGE_ROWS_DEF,
    parameter int IMAGE_COLS = IMAGE_COLS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // pixel_row, pixel_col, depth_sample, zero pad
    input  wire logic [39:0]            s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // clamped_depth, point_x, point_y, point_z, image_row, image_col, zero pad
    output logic [111:0]                m_tdata,
    // point_valid
    output logic [0:0]                  m_tuser,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam logic signed [RAW_W-1:0] RAW_LIMIT = RAW_W'(DEPTH_LIMIT);

    logic [ROT_ROW_W-1:0]   rot_row0_reg;
    logic [ROT_ROW_W-1:0]   rot_row1_reg;
    logic [ROT_ROW_W-1:0]   rot_row2_reg;
    logic [SHIFT_W-1:0]     shift_x_reg;
    logic [SHIFT_W-1:0]     shift_y_reg;
    logic [SHIFT_W-1:0]     shift_z_reg;
    logic [FOCAL_W-1:0]     inv_focal_reg;

    logic [ROW_IDX_W-1:0]       pixel_row;
    logic [COL_IDX_W-1:0]       pixel_col;
    logic signed [RAW_W-1:0]    depth_sample;
    logic [DEPTH_W-1:0]         depth_clamp;
    logic                       depth_ok;

    logic [STAGES-1:0]      stg_valid_reg;
    logic [STAGES-1:0]      stg_valid_next;
    logic [STAGES-1:0]      stg_ready;
    stage_ctrl_t            ctrl;

    logic                   ok_reg [STAGES];
    logic [DEPTH_W-1:0]     depth_reg [STAGES];

    logic signed [XY_W-1:0] cam_x;
    logic signed [XY_W-1:0] cam_y;
    logic [ROT_ROW_W-1:0]   rot_rows [3];
    logic [SHIFT_W-1:0]     shifts [3];
    logic signed [PT_W-1:0] point [3];
    logic [IMG_ROW_W-1:0]   image_row;
    logic [IMG_COL_W-1:0]   image_col;

    logic [PT_W-1:0]        point_x;
    logic [PT_W-1:0]        point_y;
    logic [PT_W-1:0]        point_z;
    logic [IMG_ROW_W-1:0]   image_row_out;
    logic [IMG_COL_W-1:0]   image_col_out;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_row0_reg  <= ROT_ROW0_RST;
            rot_row1_reg  <= ROT_ROW1_RST;
            rot_row2_reg  <= ROT_ROW2_RST;
            shift_x_reg   <= '0;
            shift_y_reg   <= '0;
            shift_z_reg   <= '0;
            inv_focal_reg <= INV_FOCAL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_e'(cfg_index))
                REG_ROT_ROW0:  rot_row0_reg  <= cfg_wdata;
                REG_ROT_ROW1:  rot_row1_reg  <= cfg_wdata;
                REG_ROT_ROW2:  rot_row2_reg  <= cfg_wdata;
                REG_SHIFT_X:   shift_x_reg   <= cfg_wdata[SHIFT_W-1:0];
                REG_SHIFT_Y:   shift_y_reg   <= cfg_wdata[SHIFT_W-1:0];
                REG_SHIFT_Z:   shift_z_reg   <= cfg_wdata[SHIFT_W-1:0];
                REG_INV_FOCAL: inv_focal_reg <= cfg_wdata[FOCAL_W-1:0];
                default: ;
            endcase
        end
    end

    // input unpack and depth clamp
    assign pixel_row    = s_tdata[8:0];
    assign pixel_col    = s_tdata[18:9];
    assign depth_sample = $signed(s_tdata[36:19]);

    assign depth_ok    = (depth_sample > 0) && (depth_sample < RAW_LIMIT);
    assign depth_clamp = ((depth_sample < 0) || (depth_sample >= RAW_LIMIT))
                       ? DEPTH_LIMIT : depth_sample[DEPTH_W-1:0];

    // stage handshake, a stage takes new data when empty or draining
    always_comb
    begin
        stg_ready[STAGES-1] = !stg_valid_reg[STAGES-1] || m_tready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            stg_ready[i] = !stg_valid_reg[i] || stg_ready[i+1];
        end
        stg_valid_next[0] = stg_ready[0] ? s_tvalid : stg_valid_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            stg_valid_next[i] = stg_ready[i] ? stg_valid_reg[i-1] : stg_valid_reg[i];
        end
    end

    assign ctrl.load = stg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= '0;
        else
            stg_valid_reg <= stg_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (stg_ready[0])
        begin
            ok_reg[0]    <= depth_ok;
            depth_reg[0] <= depth_clamp;
        end
        for (int i = 1; i < STAGES; i++)
        begin
            if (stg_ready[i])
            begin
                ok_reg[i]    <= ok_reg[i-1];
                depth_reg[i] <= depth_reg[i-1];
            end
        end
    end

    dbp_project #(
        .DEPTH_ROWS (DEPTH_ROWS),
        .DEPTH_COLS (DEPTH_COLS)
    ) u_project (
        .clk       (clk),
        .ctrl      (ctrl),
        .pixel_row (pixel_row),
        .pixel_col (pixel_col),
        .depth     (depth_clamp),
        .inv_focal (inv_focal_reg),
        .cam_x     (cam_x),
        .cam_y     (cam_y)
    );

    assign rot_rows[0] = rot_row0_reg;
    assign rot_rows[1] = rot_row1_reg;
    assign rot_rows[2] = rot_row2_reg;
    assign shifts[0]   = shift_x_reg;
    assign shifts[1]   = shift_y_reg;
    assign shifts[2]   = shift_z_reg;

    dbp_rotate u_rotate (
        .clk       (clk),
        .ctrl      (ctrl),
        .cam_x     (cam_x),
        .cam_y     (cam_y),
        .cam_z     (depth_reg[2]),
        .rot_row   (rot_rows),
        .shift_val (shifts),
        .point     (point)
    );

    dbp_index #(
        .IDX_W (ROW_IDX_W),
        .OUT_W (IMG_ROW_W),
        .TO    (IMAGE_ROWS),
        .FROM  (DEPTH_ROWS)
    ) u_row_index (
        .clk    (clk),
        .ctrl   (ctrl),
        .idx    (pixel_row),
        .scaled (image_row)
    );

    dbp_index #(
        .IDX_W (COL_IDX_W),
        .OUT_W (IMG_COL_W),
        .TO    (IMAGE_COLS),
        .FROM  (DEPTH_COLS)
    ) u_col_index (
        .clk    (clk),
        .ctrl   (ctrl),
        .idx    (pixel_col),
        .scaled (image_col)
    );

    // invalid points report zero coordinates and indices
    assign point_x       = ok_reg[STAGES-1] ? point[0] : '0;
    assign point_y       = ok_reg[STAGES-1] ? point[1] : '0;
    assign point_z       = ok_reg[STAGES-1] ? point[2] : '0;
    assign image_row_out = ok_reg[STAGES-1] ? image_row : '0;
    assign image_col_out = ok_reg[STAGES-1] ? image_col : '0;

    assign s_tready = stg_ready[0];
    assign m_tvalid = stg_valid_reg[STAGES-1];
    assign m_tuser  = ok_reg[STAGES-1];
    assign m_tdata  = {3'b000, image_col_out, image_row_out,
                       point_z, point_y, point_x, depth_reg[STAGES-1]};

    `DBP_ASSERT_IMP(a_empty_out_ready, clk, rst_n, !m_tvalid, s_tready,
        "input stalled while output stage empty")

    `DBP_ASSERT_IMP(a_full_stall, clk, rst_n, m_tvalid && !m_tready && (&stg_valid_reg),
        !s_tready, "input accepted into a full stalled pipeline")

    `DBP_ASSERT_NXT(a_drain_bubble, clk, rst_n,
        m_tvalid && m_tready && !stg_valid_reg[STAGES-2], !m_tvalid,
        "output transaction repeated after drain")

    `DBP_ASSERT_IMP(a_valid_depth, clk, rst_n, m_tvalid && m_tuser[0],
        (m_tdata[15:0] != 16'd0) && (m_tdata[15:0] < DEPTH_LIMIT),
        "valid point carries out-of-range depth")

endmodule

`default_nettype wire
